[rtl/ma_pkg.sv]
// shared types, constants and saturating helpers for the momentum accumulator
package ma_pkg;

    // default parameter values
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_PARTICLE_MASS = 3'd0;
    localparam logic [2:0] CFG_RIGID_MODE    = 3'd1;
    localparam logic [2:0] CFG_INERTIA_ROW0  = 3'd2;
    localparam logic [2:0] CFG_INERTIA_ROW1  = 3'd3;
    localparam logic [2:0] CFG_INERTIA_ROW2  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 60;
    localparam int INERTIA_W   = 20;

    // reset values of the registers
    localparam logic [31:0] MASS_RST = 32'h0001_0000;
    localparam logic [59:0] ROW0_RST = 60'h000_0000_0001_0000;
    localparam logic [59:0] ROW1_RST = 60'h000_0010_0000_0000;
    localparam logic [59:0] ROW2_RST = 60'h100_0000_0000_0000;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] lin_vel_x;
        logic signed [31:0] lin_vel_y;
        logic signed [31:0] lin_vel_z;
        logic signed [31:0] ang_vel_x;
        logic signed [31:0] ang_vel_y;
        logic signed [31:0] ang_vel_z;
        logic               last_particle;
    } ma_in_t;

    typedef struct packed {
        logic signed [63:0] linear_sum_x;
        logic signed [63:0] linear_sum_y;
        logic signed [63:0] linear_sum_z;
        logic signed [63:0] angular_sum_x;
        logic signed [63:0] angular_sum_y;
        logic signed [63:0] angular_sum_z;
    } ma_out_t;

    // register file contents handed to the core
    typedef struct packed {
        logic [31:0]      particle_mass;
        logic             rigid_mode;
        logic [2:0][59:0] inertia;
    } ma_cfg_t;

    // saturating signed 64-bit add
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // saturating signed 64-bit subtract
    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // sign extend a 20-bit inertia entry
    function automatic logic [63:0] sext_inertia(input logic [INERTIA_W-1:0] e);
        return {{(64-INERTIA_W){e[INERTIA_W-1]}}, e};
    endfunction

endpackage

[rtl/ma_mulq.sv]
// iterative 64x64 signed fixed-point multiplier with shift and saturation
module ma_mulq
    import ma_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0]         a_reg, a_next;
    logic [63:0]         b_reg, b_next;
    logic [127:0]        acc_reg, acc_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic signed [32:0]  a_part;
    logic signed [32:0]  b_part;
    logic signed [65:0]  pp;
    logic [127:0]        pp_ext;
    logic [127:0]        pp_shift;
    logic signed [127:0] q;
    logic                ovf;

    // pick one 32-bit digit of each operand, the upper digit signed
    always_comb begin
        a_part = cnt_reg[0] ? $signed({a_reg[63], a_reg[63:32]}) : $signed({1'b0, a_reg[31:0]});
        b_part = cnt_reg[1] ? $signed({b_reg[63], b_reg[63:32]}) : $signed({1'b0, b_reg[31:0]});
        pp     = a_part * b_part;
        pp_ext = {{62{pp[65]}}, pp};
    end

    // align the partial product
    always_comb begin
        case (cnt_reg)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = pp_ext << 32;
            2'd2:    pp_shift = pp_ext << 32;
            2'd3:    pp_shift = pp_ext << 64;
            default: pp_shift = pp_ext;
        endcase
    end

    // sequence four partial products
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp_shift;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // arithmetic shift right, clamp to the signed 64-bit range
    always_comb begin
        q   = $signed(acc_reg) >>> FRAC_BITS;
        ovf = !((&q[127:63]) || !(|q[127:63]));
        if (ovf) begin
            result = q[127] ? S64_MIN : S64_MAX;
        end else begin
            result = q[63:0];
        end
    end

    assign done = done_reg;

endmodule

[rtl/ma_core.sv]
// per-particle sequencer, operand selection and momentum accumulators
module ma_core
    import ma_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  ma_cfg_t cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  ma_in_t  in_item,
    input  logic    out_busy,
    output logic    res_valid,
    output ma_out_t res_data
);

    localparam int SH = 64 - DATA_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_ACC   = 2'd3;

    localparam logic [2:0] TERM_CROSS_A = 3'd0;
    localparam logic [2:0] TERM_CROSS_B = 3'd1;
    localparam logic [2:0] TERM_LAST    = 3'd4;

    logic [1:0]       state_reg, state_next;
    ma_in_t           item_reg, item_next;
    logic             lin_phase_reg, lin_phase_next;
    logic [1:0]       comp_reg, comp_next;
    logic [2:0]       term_reg, term_next;
    logic [2:0][63:0] p_reg, p_next;
    logic [2:0][63:0] ang_reg, ang_next;
    logic [63:0]      tmp_reg, tmp_next;
    logic [2:0][63:0] lin_acc_reg, lin_acc_next;
    logic [2:0][63:0] ang_acc_reg, ang_acc_next;

    logic             mul_start;
    logic [63:0]      op_a;
    logic [63:0]      op_b;
    logic             mul_done;
    logic [63:0]      mul_res;

    logic [1:0]       idx_up;
    logic [1:0]       idx_dn;
    logic [1:0]       col;
    logic [2:0]       term_end;
    logic [59:0]      row;
    logic [19:0]      ient;
    logic [31:0]      pos_f;
    logic [31:0]      pos_up;
    logic [31:0]      pos_dn;
    logic [31:0]      lvel_f;
    logic [31:0]      avel_f;
    logic [2:0][63:0] lin_sum;
    logic [2:0][63:0] ang_sum;

    // read a value field as a signed DATA_WIDTH number
    function automatic logic [63:0] sext_dw(input logic [31:0] f);
        logic [63:0] t;
        t = {32'd0, f} << SH;
        return $signed(t) >>> SH;
    endfunction

    function automatic logic [31:0] pick3(input logic [1:0] i, input logic [31:0] f0,
                                          input logic [31:0] f1, input logic [31:0] f2);
        case (i)
            2'd0:    return f0;
            2'd1:    return f1;
            default: return f2;
        endcase
    endfunction

    // cyclic neighbors of the current component
    assign idx_up   = (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
    assign idx_dn   = (comp_reg == 2'd0) ? 2'd2 : comp_reg - 2'd1;
    assign col      = term_reg[1:0] - 2'd2;
    assign term_end = cfg.rigid_mode ? TERM_LAST : TERM_CROSS_B;

    // field selection
    always_comb begin
        pos_up = pick3(idx_up, item_reg.pos_x, item_reg.pos_y, item_reg.pos_z);
        pos_dn = pick3(idx_dn, item_reg.pos_x, item_reg.pos_y, item_reg.pos_z);
        pos_f  = (term_reg == TERM_CROSS_A) ? pos_up : pos_dn;
        lvel_f = pick3(comp_reg, item_reg.lin_vel_x, item_reg.lin_vel_y, item_reg.lin_vel_z);
        avel_f = pick3(col, item_reg.ang_vel_x, item_reg.ang_vel_y, item_reg.ang_vel_z);
        row    = cfg.inertia[comp_reg];
        case (col)
            2'd0:    ient = row[19:0];
            2'd1:    ient = row[39:20];
            default: ient = row[59:40];
        endcase
    end

    // multiplier operands for the current step
    always_comb begin
        if (lin_phase_reg) begin
            op_a = {32'd0, cfg.particle_mass};
            op_b = sext_dw(lvel_f);
        end else if (term_reg == TERM_CROSS_A) begin
            op_a = sext_dw(pos_f);
            op_b = p_reg[idx_dn];
        end else if (term_reg == TERM_CROSS_B) begin
            op_a = sext_dw(pos_f);
            op_b = p_reg[idx_up];
        end else begin
            op_a = sext_inertia(ient);
            op_b = sext_dw(avel_f);
        end
    end

    ma_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // per-particle totals into the accumulators
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lin_sum[j] = sat_add64(lin_acc_reg[j], p_reg[j]);
            ang_sum[j] = sat_add64(ang_acc_reg[j], ang_reg[j]);
        end
    end

    assign res_data.linear_sum_x  = $signed(lin_sum[0]);
    assign res_data.linear_sum_y  = $signed(lin_sum[1]);
    assign res_data.linear_sum_z  = $signed(lin_sum[2]);
    assign res_data.angular_sum_x = $signed(ang_sum[0]);
    assign res_data.angular_sum_y = $signed(ang_sum[1]);
    assign res_data.angular_sum_z = $signed(ang_sum[2]);

    assign in_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        lin_phase_next = lin_phase_reg;
        comp_next      = comp_reg;
        term_next      = term_reg;
        p_next         = p_reg;
        ang_next       = ang_reg;
        tmp_next       = tmp_reg;
        lin_acc_next   = lin_acc_reg;
        ang_acc_next   = ang_acc_reg;
        mul_start      = 1'b0;
        res_valid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next      = in_item;
                    lin_phase_next = 1'b1;
                    comp_next      = 2'd0;
                    term_next      = TERM_CROSS_A;
                    state_next     = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = ST_ISSUE;
                    if (lin_phase_reg) begin
                        // linear momentum
                        p_next[comp_reg] = mul_res;
                        if (comp_reg == 2'd2) begin
                            lin_phase_next = 1'b0;
                            comp_next      = 2'd0;
                        end else begin
                            comp_next = comp_reg + 2'd1;
                        end
                    end else begin
                        // cross product terms, then inertia terms
                        if (term_reg == TERM_CROSS_A) begin
                            tmp_next = mul_res;
                        end else if (term_reg == TERM_CROSS_B) begin
                            ang_next[comp_reg] = sat_sub64(tmp_reg, mul_res);
                        end else begin
                            ang_next[comp_reg] = sat_add64(ang_reg[comp_reg], mul_res);
                        end
                        if (term_reg == term_end) begin
                            term_next = TERM_CROSS_A;
                            if (comp_reg == 2'd2) begin
                                state_next = ST_ACC;
                            end else begin
                                comp_next = comp_reg + 2'd1;
                            end
                        end else begin
                            term_next = term_reg + 3'd1;
                        end
                    end
                end
            end
            ST_ACC: begin
                if (!item_reg.last_particle) begin
                    lin_acc_next = lin_sum;
                    ang_acc_next = ang_sum;
                    state_next   = ST_IDLE;
                end else if (!out_busy) begin
                    res_valid    = 1'b1;
                    lin_acc_next = '0;
                    ang_acc_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lin_phase_reg <= 1'b1;
            comp_reg      <= 2'd0;
            term_reg      <= TERM_CROSS_A;
            lin_acc_reg   <= '0;
            ang_acc_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            lin_phase_reg <= lin_phase_next;
            comp_reg      <= comp_next;
            term_reg      <= term_next;
            lin_acc_reg   <= lin_acc_next;
            ang_acc_reg   <= ang_acc_next;
        end
        item_reg <= item_next;
        p_reg    <= p_next;
        ang_reg  <= ang_next;
        tmp_reg  <= tmp_next;
    end

endmodule

[rtl/momentum_accumulator.sv]
// top level: configuration registers, core and result register
//
// Sums linear momentum (mass times velocity) and angular momentum (position
// cross momentum, plus inertia-mass matrix times angular velocity in rigid
// mode) over a set of particles into six saturating Q48.16 totals, which are
// delivered as one transfer on the particle marked last. All products go
// through one shared multiplier that forms a 64x64 product as four 33x33
// partial products, one product at a time. A particle needs 9 products
// as a point particle and 18 in rigid mode; s_ready is low while it
// occupies the block. A finished result waits in the output register
// while the next particle is already taken. Configuration writes take
// effect at once and belong between particles.
module momentum_accumulator
    import ma_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ma_in_t                 s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ma_out_t                m_result
);

    ma_cfg_t cfg_reg, cfg_next;
    logic    m_valid_reg, m_valid_next;
    ma_out_t m_result_reg, m_result_next;
    logic    res_valid;
    ma_out_t res_data;
    logic    out_busy;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PARTICLE_MASS: cfg_next.particle_mass = cfg_wdata[31:0];
                CFG_RIGID_MODE:    cfg_next.rigid_mode    = cfg_wdata[0];
                CFG_INERTIA_ROW0:  cfg_next.inertia[0]    = cfg_wdata;
                CFG_INERTIA_ROW1:  cfg_next.inertia[1]    = cfg_wdata;
                CFG_INERTIA_ROW2:  cfg_next.inertia[2]    = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    ma_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_busy  (out_busy),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // output register, freed by the transfer in the same cycle
    assign out_busy = m_valid_reg && !m_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (res_valid) begin
            m_valid_next  = 1'b1;
            m_result_next = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.particle_mass <= MASS_RST;
            cfg_reg.rigid_mode    <= 1'b0;
            cfg_reg.inertia[0]    <= ROW0_RST;
            cfg_reg.inertia[1]    <= ROW1_RST;
            cfg_reg.inertia[2]    <= ROW2_RST;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

[tb/sv/momentum_accumulator_test.sv]
// self-checking testbench for the momentum accumulator: random particle sets against a predictor
`timescale 1ns / 100ps

module momentum_accumulator_test;
    import ma_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int PRESSURE_SETS = 20;

    localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] WIDE_MIN = -WIDE_MAX - 128'sd1;

    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [19:0] ENTRY_MAX = 20'h7_FFFF;
    localparam logic [19:0] ENTRY_MIN = 20'h8_0000;

    // predicted totals and the queue of totals still owed by the block
    class momentum_tally;
        logic [31:0]        mass;
        bit                 rigid;
        logic [59:0]        rows [3];
        logic signed [63:0] lin_sum [3];
        logic signed [63:0] ang_sum [3];
        ma_out_t            totals_due [$];
        int                 mismatches;

        function new();
            mass       = MASS_RST;
            rigid      = 1'b0;
            rows[0]    = ROW0_RST;
            rows[1]    = ROW1_RST;
            rows[2]    = ROW2_RST;
            mismatches = 0;
            for (int j = 0; j < 3; j++) begin
                lin_sum[j] = '0;
                ang_sum[j] = '0;
            end
        endfunction

        // exact product, floor shift by the fraction bits, clamp to 64 bits
        function logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [127:0] wa, wb, prod;
            wa   = a;
            wb   = b;
            prod = (wa * wb) >>> FRAC_BITS_DEF;
            if (prod > WIDE_MAX) return S64_MAX;
            if (prod < WIDE_MIN) return S64_MIN;
            return prod[63:0];
        endfunction

        function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
            return s[63:0];
        endfunction

        function logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic [64:0] s;
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
            return s[63:0];
        endfunction

        function void note_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PARTICLE_MASS: mass    = data[31:0];
                CFG_RIGID_MODE:    rigid   = data[0];
                CFG_INERTIA_ROW0:  rows[0] = data;
                CFG_INERTIA_ROW1:  rows[1] = data;
                CFG_INERTIA_ROW2:  rows[2] = data;
                default: ;
            endcase
        endfunction

        // fold one particle into the running sums, owe totals on the last one
        function void tally_particle(ma_in_t p);
            logic signed [63:0] pos [3];
            logic signed [63:0] vel [3];
            logic signed [63:0] spin [3];
            logic signed [63:0] mom [3];
            logic signed [63:0] ang [3];
            logic signed [63:0] m, coef;
            logic signed [19:0] entry;
            ma_out_t            tot;
            pos[0]  = p.pos_x;
            pos[1]  = p.pos_y;
            pos[2]  = p.pos_z;
            vel[0]  = p.lin_vel_x;
            vel[1]  = p.lin_vel_y;
            vel[2]  = p.lin_vel_z;
            spin[0] = p.ang_vel_x;
            spin[1] = p.ang_vel_y;
            spin[2] = p.ang_vel_z;
            m = {32'd0, mass};
            for (int j = 0; j < 3; j++) mom[j] = mul_q(m, vel[j]);
            // position cross momentum
            ang[0] = sub_sat(mul_q(pos[1], mom[2]), mul_q(pos[2], mom[1]));
            ang[1] = sub_sat(mul_q(pos[2], mom[0]), mul_q(pos[0], mom[2]));
            ang[2] = sub_sat(mul_q(pos[0], mom[1]), mul_q(pos[1], mom[0]));
            // inertia-mass matrix times angular velocity, one saturating add per entry
            if (rigid) begin
                for (int j = 0; j < 3; j++) begin
                    for (int c = 0; c < 3; c++) begin
                        entry  = rows[j][INERTIA_W*c +: INERTIA_W];
                        coef   = entry;
                        ang[j] = add_sat(ang[j], mul_q(coef, spin[c]));
                    end
                end
            end
            for (int j = 0; j < 3; j++) begin
                lin_sum[j] = add_sat(lin_sum[j], mom[j]);
                ang_sum[j] = add_sat(ang_sum[j], ang[j]);
            end
            if (p.last_particle) begin
                tot.linear_sum_x  = lin_sum[0];
                tot.linear_sum_y  = lin_sum[1];
                tot.linear_sum_z  = lin_sum[2];
                tot.angular_sum_x = ang_sum[0];
                tot.angular_sum_y = ang_sum[1];
                tot.angular_sum_z = ang_sum[2];
                totals_due = {totals_due, tot};
                for (int j = 0; j < 3; j++) begin
                    lin_sum[j] = '0;
                    ang_sum[j] = '0;
                end
            end
        endfunction

        function void check_totals(ma_out_t got);
            ma_out_t     want;
            logic [63:0] w [6];
            logic [63:0] g [6];
            string       names [6];
            names = '{"linear_sum_x", "linear_sum_y", "linear_sum_z",
                      "angular_sum_x", "angular_sum_y", "angular_sum_z"};
            if (totals_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected totals transfer at %0t: %p", $realtime, got);
                return;
            end
            want = totals_due.pop_front();
            w = '{want.linear_sum_x, want.linear_sum_y, want.linear_sum_z,
                  want.angular_sum_x, want.angular_sum_y, want.angular_sum_z};
            g = '{got.linear_sum_x, got.linear_sum_y, got.linear_sum_z,
                  got.angular_sum_x, got.angular_sum_y, got.angular_sum_z};
            for (int k = 0; k < 6; k++) begin
                if (g[k] !== w[k]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%s mismatch at %0t: expected %0d, actual %0d",
                                 names[k], $realtime, $signed(w[k]), $signed(g[k]));
                end
            end
        endfunction

        function int pending();
            return totals_due.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    ma_in_t                 s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    ma_out_t                m_result;

    momentum_tally model = new();
    bit            tx_idle      = 1'b1;
    bit            rx_idle      = 1'b1;
    bit            hold_request = 1'b0;
    int unsigned   cycle_count  = 0;

    momentum_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // field values biased toward the extremes and small magnitudes
    function automatic logic [31:0] rand_fixed();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [59:0] rand_word();
        return 60'({$urandom(), $urandom()});
    endfunction

    function automatic ma_in_t make_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                             logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                                             logic last);
        ma_in_t p;
        p.pos_x         = px;
        p.pos_y         = py;
        p.pos_z         = pz;
        p.lin_vel_x     = vx;
        p.lin_vel_y     = vy;
        p.lin_vel_z     = vz;
        p.ang_vel_x     = wx;
        p.ang_vel_y     = wy;
        p.ang_vel_z     = wz;
        p.last_particle = last;
        return p;
    endfunction

    function automatic ma_in_t rand_particle(logic last);
        return make_particle(rand_fixed(), rand_fixed(), rand_fixed(),
                             rand_fixed(), rand_fixed(), rand_fixed(),
                             rand_fixed(), rand_fixed(), rand_fixed(), last);
    endfunction

    function automatic logic [59:0] rand_row(int flavor);
        if (flavor == 0) return {3{ENTRY_MAX}};
        if (flavor == 2) return {3{ENTRY_MIN}};
        case ($urandom_range(0, 3))
            0: return {20'($urandom_range(0, 32'h2_0000)), 20'($urandom_range(0, 32'h2_0000)),
                       20'($urandom_range(0, 32'h2_0000))};
            1: return {ENTRY_MIN, 20'd0, ENTRY_MAX};
            default: return rand_word();
        endcase
    endfunction

    // one register write on the configuration port
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model.note_write(idx, data);
    endtask

    // full register set; flavor picks the extremes for the first phases
    task automatic program_regs(int flavor);
        logic [31:0] mass;
        logic        rigid;
        case (flavor)
            0: mass = 32'hFFFF_FFFF;
            1: mass = '0;
            default: begin
                case ($urandom_range(0, 3))
                    0: mass = Q_ONE;
                    1: mass = $urandom_range(0, 32'h0004_0000);
                    default: mass = $urandom();
                endcase
            end
        endcase
        rigid = (flavor == 0 || flavor == 2) ? 1'b1 : 1'($urandom_range(0, 1));
        write_reg(CFG_PARTICLE_MASS, {28'($urandom()), mass});
        write_reg(CFG_RIGID_MODE, {59'(rand_word()), rigid});
        write_reg(CFG_INERTIA_ROW0, rand_row(flavor));
        write_reg(CFG_INERTIA_ROW1, rand_row(flavor));
        write_reg(CFG_INERTIA_ROW2, rand_row(flavor));
        // index past the last register must leave everything alone
        write_reg(CFG_INERTIA_ROW2 + 3'($urandom_range(1, 3)), rand_word());
    endtask

    // offer one particle and hold it until the transfer
    task automatic push_particle(ma_in_t p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= p;
        do @(posedge aclk); while (!s_ready);
        model.tally_particle(p);
    endtask

    // particle sets of random length, the last one of each flagged
    task automatic run_sets(int count, bit singles);
        int remaining, len;
        remaining = count;
        while (remaining > 0) begin
            if (singles) len = 1;
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(5, 12);
            else len = $urandom_range(1, 4);
            if (len > remaining) len = remaining;
            for (int i = 0; i < len; i++) push_particle(rand_particle(i == len - 1));
            remaining -= len;
        end
    endtask

    // drop valid, let all owed totals arrive and the core go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (model.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = rx_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            model.check_totals(m_result);
        end
    end

    // stimulus
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: point particles, angular velocity ignored
        push_particle(make_particle('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
        push_particle(make_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MAX, Q_MAX, Q_MAX, 1'b0));
        push_particle(make_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    Q_MIN, Q_MIN, Q_MIN, 1'b0));
        push_particle(make_particle(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                    Q_MIN, Q_MAX, Q_MIN, 1'b0));
        push_particle(make_particle(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -Q_ONE, Q_ONE >> 1, 2 * Q_ONE,
                                    Q_ONE, -Q_ONE, Q_ONE, 1'b1));
        settle();

        // heaviest mass, rigid, extreme inertia entries, junk above register widths
        write_reg(CFG_PARTICLE_MASS, {28'hFFF_FFFF, 32'hFFFF_FFFF});
        write_reg(CFG_RIGID_MODE, {59'h5A5_A5A5_A5A5_A5A5, 1'b1});
        write_reg(CFG_INERTIA_ROW0, {3{ENTRY_MAX}});
        write_reg(CFG_INERTIA_ROW1, {3{ENTRY_MIN}});
        write_reg(CFG_INERTIA_ROW2, {ENTRY_MIN, 20'd0, ENTRY_MAX});
        write_reg(CFG_INERTIA_ROW2 + 3'd1, '1);

        // cross product clamps high, then the running sums do
        repeat (3) push_particle(make_particle(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                               Q_MAX, Q_MAX, Q_MAX, 1'b0));
        push_particle(make_particle(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MAX, Q_MAX, Q_MAX, 1'b1));
        // same toward the negative limit
        repeat (3) push_particle(make_particle(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                               Q_MIN, Q_MIN, Q_MIN, 1'b0));
        push_particle(make_particle(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MIN, Q_MIN, Q_MIN, 1'b1));
        push_particle(make_particle(rand_fixed(), rand_fixed(), rand_fixed(),
                                    Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        settle();

        // zero mass: only the inertia term is left
        write_reg(CFG_PARTICLE_MASS, '0);
        push_particle(make_particle(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MAX, Q_MIN, Q_MAX, 1'b1));
        settle();

        // random phases, each with its own register set
        for (int phase = 0; phase < PHASES; phase++) begin
            tx_idle = (phase % 3 != 2);
            rx_idle = (phase % 3 != 2);
            program_regs(phase);
            if (phase == 4) begin
                // receiver holds off while single-particle sets pile up
                hold_request = 1'b1;
                run_sets(PRESSURE_SETS, 1'b1);
                run_sets(PHASE_ITEMS - PRESSURE_SETS, 1'b0);
            end else begin
                run_sets(PHASE_ITEMS, 1'b0);
            end
            settle();
        end

        if (model.mismatches == 0 && model.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
